/* src/softmax_vector_top_macros.svh */
// assertion macros for the softmax vector block
`ifndef SOFTMAX_VECTOR_TOP_MACROS_SVH
`define SOFTMAX_VECTOR_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define SMV_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SMV_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

/* src/smv_pkg.sv */
// types and constants for the softmax vector block
package smv_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	// exponential and divider constants
	localparam logic [16:0] LOG2E_Q15 = 17'd47274;
	localparam logic [15:0] POLY_C1 = 16'd43019;
	localparam logic [16:0] POLY_C2 = 17'd10251;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [4:0] DIV_LAST = 5'd16;

	typedef struct packed {
		logic signed [15:0] logit;
		logic last;
	} item_t;

	typedef struct packed {
		logic [15:0] probability;
		logic end_of_vector;
		logic overflowed;
	} result_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_READ   = 8'b0000_0010,
		ST_MUL0   = 8'b0000_0100,
		ST_MUL1   = 8'b0000_1000,
		ST_MUL2   = 8'b0001_0000,
		ST_EXPF   = 8'b0010_0000,
		ST_ACCUM  = 8'b0100_0000,
		ST_DIVIDE = 8'b1000_0000
	} state_t;

endpackage

/* src/softmax_vector_top.sv */
// softmax over a stored vector of Q4.12 logits, one shared multiplier and divider
//
// Usage: drive item and pulse start while busy is low; each start with busy low
// takes one word. Words without last are stored and busy stays low.
// The word with last closes the vector: busy rises and the block walks the store
// twice. The first pass forms the sum of exponentials; each element takes a
// memory read, three passes through the shared multiplier, an exponential shift
// and an accumulate.
// The second pass recomputes each exponential and runs a restoring divider,
// one quotient bit per cycle; each probability is on result for one cycle with
// result_strobe high. The last result carries end_of_vector; busy falls in the
// cycle that shows it.
// At most 64 elements are stored; elements beyond the store depth are dropped
// and every result of that vector carries overflowed. The receiver cannot
// stall: results are not held.
// Reset clears count, maximum, sum and flags; the logit store is not cleared.
module softmax_vector_top
	import smv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    result_strobe,
	output result_t result
);

	state_t state_q;
	logic [15:0] mem_q [MAX_ELEMENTS];
	logic [15:0] mem_rd_q;
	logic [CNT_W-1:0] count_q;
	logic [ADDR_W-1:0] idx_q;
	logic signed [15:0] max_q;
	logic [22:0] sum_q;
	logic ovf_q;
	logic out_phase_q;
	logic [33:0] prod_q;
	logic [11:0] u_q;
	logic [4:0] n_q;
	logic [16:0] e_q;
	logic [23:0] rem_q;
	logic [15:0] quo_q;
	logic [4:0] dcnt_q;
	logic strobe_q;
	result_t result_q;

	logic accept;
	logic room;
	logic last_elem;
	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [16:0] diff;
	logic [16:0] m_val;
	logic [15:0] inner;
	logic [16:0] p_val;
	logic [16:0] e_val;
	logic [23:0] trial;
	logic take;
	logic [16:0] quo_full;

	assign accept = start && !busy;
	assign room = count_q < CNT_W'(MAX_ELEMENTS);
	assign last_elem = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign busy = state_q != ST_IDLE;
	assign result_strobe = strobe_q;
	assign result = result_q;

	// exponential datapath pieces
	assign diff = 17'(max_q) - 17'($signed(mem_rd_q));
	assign m_val = prod_q[31:15];
	assign inner = POLY_C1 - prod_q[27:12];
	assign p_val = ONE_Q16 - prod_q[28:12];
	assign e_val = (n_q > 5'd16) ? 17'd0 : (p_val >> n_q);

	// divider step
	assign trial = {rem_q[22:0], (dcnt_q == 5'd0) ? e_q[0] : 1'b0};
	assign take = trial >= {1'b0, sum_q};
	assign quo_full = {quo_q, take};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL0: begin
				mul_a = {1'b0, diff[15:0]};
				mul_b = LOG2E_Q15;
			end
			ST_MUL1: begin
				mul_a = POLY_C2;
				mul_b = {5'd0, m_val[11:0]};
			end
			ST_MUL2: begin
				mul_a = {5'd0, u_q};
				mul_b = {1'b0, inner};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// logit store
	always_ff @(posedge clk) begin
		if (accept && room)
			mem_q[count_q[ADDR_W-1:0]] <= item.logit;
		mem_rd_q <= mem_q[idx_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 34'(mul_a * mul_b);
		if (state_q == ST_MUL1) begin
			u_q <= m_val[11:0];
			n_q <= m_val[16:12];
		end
		if (state_q == ST_EXPF) begin
			e_q <= e_val;
			rem_q <= {8'd0, e_val[16:1]};
		end
		if (state_q == ST_DIVIDE) begin
			rem_q <= take ? (trial - {1'b0, sum_q}) : trial;
			quo_q <= quo_full[15:0];
		end
		if (state_q == ST_DIVIDE && dcnt_q == DIV_LAST) begin
			result_q.probability <= quo_full[16] ? 16'hFFFF : quo_full[15:0];
			result_q.end_of_vector <= last_elem;
			result_q.overflowed <= ovf_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			max_q <= 16'sh8000;
			sum_q <= '0;
			ovf_q <= 1'b0;
			out_phase_q <= 1'b0;
			dcnt_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
							if (item.logit > max_q)
								max_q <= item.logit;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							idx_q <= '0;
							out_phase_q <= 1'b0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_EXPF;
				ST_EXPF: begin
					dcnt_q <= '0;
					state_q <= out_phase_q ? ST_DIVIDE : ST_ACCUM;
				end
				ST_ACCUM: begin
					sum_q <= sum_q + 23'(e_q);
					state_q <= ST_READ;
					if (last_elem) begin
						idx_q <= '0;
						out_phase_q <= 1'b1;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				ST_DIVIDE: begin
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == DIV_LAST) begin
						strobe_q <= 1'b1;
						if (last_elem) begin
							count_q <= '0;
							max_q <= 16'sh8000;
							sum_q <= '0;
							ovf_q <= 1'b0;
							out_phase_q <= 1'b0;
							idx_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "softmax_vector_top_macros.svh"

	`SMV_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_ELEMENTS), "count beyond depth")
	`SMV_ASSERT_NEXT(a_close_starts, accept && item.last, state_q == ST_READ, "vector not closed")
	`SMV_ASSERT_SAME(a_strobe_after_div, strobe_q, $past(state_q == ST_DIVIDE), "stray result")
	`SMV_ASSERT_SAME(a_accum_in_sum, state_q == ST_ACCUM, !out_phase_q, "accumulate in output pass")

endmodule

/* sim/softmax_vector_top_test.sv */
// self-checking bench for the softmax vector block: directed and random vectors, predicted probabilities
module softmax_vector_top_test;
	import smv_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    result_strobe;
	result_t result;

	softmax_vector_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .result_strobe(result_strobe), .result(result)
	);

	localparam int STALL_LIMIT = 20000;

	item_t   pending_words[$];
	result_t expected_probs[$];
	int      errors = 0;
	int      stall_cycles = 0;
	int      gap_left;
	bit      stim_done;
	bit      took;

	// predictor state
	logic signed [15:0] vec_store [MAX_ELEMENTS];
	int                 vec_count;
	logic signed [15:0] vec_max;
	bit                 vec_dropped;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// power-of-two exponential of x - max, Q1.16
	function automatic logic [16:0] exp_q16(logic signed [15:0] x, logic signed [15:0] mx);
		logic [16:0] diff;
		logic [33:0] m;
		logic [21:0] n;
		logic [11:0] u;
		logic [31:0] inner;
		logic [31:0] p;
		diff = 17'(mx - x);
		m = (34'(diff) * 34'(LOG2E_Q15)) >> 15;
		n = 22'(m >> 12);
		u = m[11:0];
		inner = 32'(POLY_C1) - ((32'(POLY_C2) * 32'(u)) >> 12);
		p = 32'(ONE_Q16) - ((32'(u) * inner) >> 12);
		if (n > 16)
			return 17'd0;
		return 17'(p >> n);
	endfunction

	// take one word into the predictor; on last, queue the probabilities
	task automatic predict_word(item_t w);
		logic [22:0] sum;
		logic [39:0] q;
		result_t r;
		sum = '0;
		if (vec_count < MAX_ELEMENTS) begin
			vec_store[vec_count] = w.logit;
			vec_count++;
			if (w.logit > vec_max)
				vec_max = w.logit;
		end else begin
			vec_dropped = 1'b1;
		end
		if (!w.last)
			return;
		for (int i = 0; i < vec_count; i++)
			sum = sum + 23'(exp_q16(vec_store[i], vec_max));
		for (int i = 0; i < vec_count; i++) begin
			q = (sum != 0) ? ((40'(exp_q16(vec_store[i], vec_max)) << 16) / 40'(sum)) : 40'd0;
			r.probability = (q > 65535) ? 16'hffff : q[15:0];
			r.end_of_vector = (i + 1 == vec_count);
			r.overflowed = vec_dropped;
			expected_probs.push_back(r);
		end
		vec_count = 0;
		vec_max = 16'sh8000;
		vec_dropped = 1'b0;
	endtask

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [15:0] pick_logit();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 4000)) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_vector(int len);
		item_t w;
		for (int i = 0; i < len; i++) begin
			w.logit = pick_logit();
			w.last = (i == len - 1);
			pending_words.push_back(w);
		end
	endtask

	task automatic add_word(logic signed [15:0] x, logic l);
		item_t w;
		w.logit = x;
		w.last = l;
		pending_words.push_back(w);
	endtask

	// stimulus
	initial begin
		int total;
		int len;
		vec_count = 0;
		vec_max = 16'sh8000;
		vec_dropped = 1'b0;
		stim_done = 1'b0;
		// single element saturates
		add_word(16'sh7fff, 1'b1);
		add_word(16'sh8000, 1'b1);
		// extremes together
		add_word(16'sh8000, 1'b0);
		add_word(16'sh7fff, 1'b1);
		// equal elements
		add_word(16'sh0000, 1'b0);
		add_word(16'sh0000, 1'b0);
		add_word(16'sh0000, 1'b1);
		// small spread
		add_word(16'sh1000, 1'b0);
		add_word(16'sh0000, 1'b0);
		add_word(-16'sh1000, 1'b0);
		add_word(16'sh5555, 1'b0);
		add_word(-16'sh2aab, 1'b1);
		total = 12;
		// store full, last two elements dropped
		for (int i = 0; i < MAX_ELEMENTS + 2; i++)
			add_word(16'(i * 97 - 3000), (i == MAX_ELEMENTS + 1));
		// store exactly full
		for (int i = 0; i < MAX_ELEMENTS; i++)
			add_word(16'($urandom), (i == MAX_ELEMENTS - 1));
		total += 2 * MAX_ELEMENTS + 2;
		while (total < 160) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 8);
			add_vector(len);
			total += len;
		end
		stim_done = 1'b1;
	end

	// word taken at the rising edge
	always @(posedge clk)
		took <= start && !busy;

	// driver: change inputs on the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else if (took) begin
			// word taken at the last rising edge
			if (gap_left == 0 && pending_words.size() > 0 && pick_gap() == 0) begin
				predict_word(pending_words[0]);
				item <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
				gap_left <= pick_gap();
			end
		end else if (!start) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_words.size() > 0) begin
				predict_word(pending_words[0]);
				item <= pending_words.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if ((start && !busy) || result_strobe)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (result_strobe) begin
				if (expected_probs.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, result);
					errors++;
				end else begin
					want = expected_probs.pop_front();
					if (result.probability !== want.probability) begin
						$display("%0t: probability expected %h actual %h", $time,
							want.probability, result.probability);
						errors++;
					end
					if (result.end_of_vector !== want.end_of_vector) begin
						$display("%0t: end_of_vector expected %b actual %b", $time,
							want.end_of_vector, result.end_of_vector);
						errors++;
					end
					if (result.overflowed !== want.overflowed) begin
						$display("%0t: overflowed expected %b actual %b", $time,
							want.overflowed, result.overflowed);
						errors++;
					end
				end
			end
		end
	end

	// reset, end of run, watchdog
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		forever begin
			@(posedge clk);
			if (stall_cycles >= STALL_LIMIT) begin
				$display("softmax_vector_top verification failed");
				$finish;
			end
			if (stim_done && pending_words.size() == 0 && !start
				&& expected_probs.size() == 0 && !busy)
				break;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_probs.size() == 0)
			$display("softmax_vector_top verification clean");
		else
			$display("softmax_vector_top verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/smv_pkg.sv
src/softmax_vector_top.sv
sim/softmax_vector_top_test.sv
